// ===== design/hsv_pkg.sv =====
// shared types, constants and the divider step for the rgb to hsv converter
// no dependencies; every other design file imports this package
package hsv_pkg;

   // fixed point scales
   localparam int HUE_UNITS    = 64;
   localparam int HUE_SECTOR   = 60 * HUE_UNITS;
   localparam int HUE_FULL     = 360 * HUE_UNITS;
   localparam int SAT_ONE_LOG2 = 12;

   // field widths
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 13;

   // divider: numerators below 2**NUM_W, quotients need QUO_W bits
   localparam int NUM_W     = 20;
   localparam int QUO_W     = 13;
   localparam int DIV_STEPS = QUO_W;

   // queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // accept to result strobe: queue, divider load, steps, output register
   localparam int PIPE_LAT = DIV_STEPS + 3;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   // one classified item
   typedef struct packed {
      logic [CHAN_W-1:0] value;  // largest channel
      logic [CHAN_W-1:0] delta;  // max minus min
      logic [CHAN_W-1:0] mag;    // magnitude of the hue channel difference
      logic              neg;    // hue channel difference is negative
      sector_type        sector;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [QUO_W-1:0]  nq;   // numerator bits on top, quotient bits shift in below
   } div_type;

   // one restoring division step, one quotient bit
   function automatic div_type div_step(input div_type cur, input logic [CHAN_W-1:0] dvs);
      logic [CHAN_W:0] sh;
      logic            ge;
      div_type         res;
      sh      = {cur.rem, cur.nq[QUO_W-1]};
      ge      = (sh >= {1'b0, dvs});
      res.rem = ge ? CHAN_W'(sh - {1'b0, dvs}) : sh[CHAN_W-1:0];
      res.nq  = {cur.nq[QUO_W-2:0], ge};
      return res;
   endfunction

endpackage

// ===== design/hsv_front.sv =====
// front end: takes a pixel, finds max, min and hue sector, builds a queue entry
// depends on hsv_pkg
module hsv_front import hsv_pkg::*; (
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  fifo_stat_type     fifo_stat,
   output logic              push,
   output entry_type         push_data
);

   logic [CHAN_W-1:0] mx;
   logic [CHAN_W-1:0] mn;
   logic [CHAN_W-1:0] a;
   logic [CHAN_W-1:0] b;

   assign busy = fifo_stat.full;
   assign push = start && !fifo_stat.full;

   always_comb begin
      // ties go to red, then green
      if (req_red >= req_green && req_red >= req_blue) begin
         push_data.sector = SECTOR_RED;
         mx = req_red;
         a  = req_green;
         b  = req_blue;
      end else if (req_green >= req_blue) begin
         push_data.sector = SECTOR_GREEN;
         mx = req_green;
         a  = req_blue;
         b  = req_red;
      end else begin
         push_data.sector = SECTOR_BLUE;
         mx = req_blue;
         a  = req_red;
         b  = req_green;
      end
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      push_data.value = mx;
      push_data.delta = mx - mn;
      push_data.neg   = (a < b);
      push_data.mag   = (a < b) ? (b - a) : (a - b);
   end

endmodule

// ===== design/hsv_fifo.sv =====
// two entry queue of classified items between front and back
// depends on hsv_pkg
module hsv_fifo import hsv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  entry_type     push_data,
   input  logic          pop,
   output entry_type     head,
   output fifo_stat_type stat
);

   entry_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               do_pop;

   assign do_pop         = pop && (count_ff != '0);
   assign stat.full      = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? FIFO_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full && !do_pop |=> count_ff == (FIFO_AW+1)'(FIFO_DEPTH) && $stable(wr_ptr_ff))
      else $error("queue written while full");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue pop lost");

endmodule

// ===== design/hsv_back.sv =====
// back end: two lockstep restoring dividers, one quotient bit per stage,
// then hue wrap and result register; depends on hsv_pkg
module hsv_back import hsv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  entry_type        load_data,
   output logic             rsp_strobe,
   output logic [HUE_W-1:0] rsp_hue,
   output logic [SAT_W-1:0] rsp_saturation,
   output logic [CHAN_W-1:0] rsp_value
);

   logic      vld_ff [DIV_STEPS+1];
   logic      vld_in [DIV_STEPS+1];
   entry_type ent_ff [DIV_STEPS+1];
   entry_type ent_in [DIV_STEPS+1];
   div_type   hdiv_ff [DIV_STEPS+1];
   div_type   hdiv_in [DIV_STEPS+1];
   div_type   sdiv_ff [DIV_STEPS+1];
   div_type   sdiv_in [DIV_STEPS+1];

   logic [NUM_W-1:0] hnum;
   logic [NUM_W-1:0] snum;

   logic              strobe_ff;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [SAT_W-1:0]  sat_ff, sat_in;
   logic [CHAN_W-1:0] value_ff;

   entry_type         last;
   logic [HUE_W-1:0]  hq;
   logic [HUE_W-1:0]  base;

   // 3840 * mag as two shifts
   assign hnum = {load_data.mag, 12'b0} - {4'b0, load_data.mag, 8'b0};
   assign snum = {load_data.delta, (NUM_W-CHAN_W)'(0)};

   always_comb begin
      vld_in[0]      = load;
      ent_in[0]      = load_data;
      // top numerator bits start in the remainder, below the divisor when it is nonzero
      hdiv_in[0].rem = CHAN_W'(hnum[NUM_W-1:QUO_W]);
      hdiv_in[0].nq  = hnum[QUO_W-1:0];
      sdiv_in[0].rem = CHAN_W'(snum[NUM_W-1:QUO_W]);
      sdiv_in[0].nq  = snum[QUO_W-1:0];
      for (int k = 1; k <= DIV_STEPS; k++) begin
         vld_in[k]  = vld_ff[k-1];
         ent_in[k]  = ent_ff[k-1];
         hdiv_in[k] = div_step(hdiv_ff[k-1], ent_ff[k-1].delta);
         sdiv_in[k] = div_step(sdiv_ff[k-1], ent_ff[k-1].value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
         ent_ff[k]  <= ent_in[k];
         hdiv_ff[k] <= hdiv_in[k];
         sdiv_ff[k] <= sdiv_in[k];
      end
   end

   // sector base, signed term and wrap; zero hue for a zero delta, zero saturation for a zero value
   always_comb begin
      last = ent_ff[DIV_STEPS];
      hq   = HUE_W'(hdiv_ff[DIV_STEPS].nq);
      case (last.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = HUE_W'(2 * HUE_SECTOR);
         SECTOR_BLUE:  base = HUE_W'(4 * HUE_SECTOR);
         default:      base = '0;
      endcase
      if (last.delta == '0) begin
         hue_in = '0;
      end else if (!last.neg) begin
         hue_in = base + hq;
      end else if (hq > base) begin
         hue_in = HUE_W'(HUE_FULL) + base - hq;
      end else begin
         hue_in = base - hq;
      end
      sat_in = (last.value == '0) ? '0 : sdiv_ff[DIV_STEPS].nq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      value_ff <= last.value;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_value      = value_ff;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> hue_ff < HUE_W'(HUE_FULL) && sat_ff <= SAT_W'(1 << SAT_ONE_LOG2))
      else $error("result out of range");

   a_black_unsaturated: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && value_ff == '0 |-> sat_ff == '0 && hue_ff == '0)
      else $error("black pixel with hue or saturation");

   a_load_to_strobe: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##(DIV_STEPS+1) strobe_ff)
      else $error("item lost in divider pipeline");

endmodule

// ===== design/rgb_to_hsv_converter_core.sv =====
// rgb to hsv converter top level: front, queue and divider back end
// path from accept (start high, busy low): queue, load, steps, output register
// throughput: one item per cycle, set by the 13 stage bit-per-stage dividers
// busy rises only when the two entry queue is full; the back end never stalls
// reset (synchronous, active high) empties the queue and clears all valid bits
// depends on hsv_pkg, hsv_front, hsv_fifo, hsv_back
module rgb_to_hsv_converter_core import hsv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_strobe,
   output logic [HUE_W-1:0]  rsp_hue,
   output logic [SAT_W-1:0]  rsp_saturation,
   output logic [CHAN_W-1:0] rsp_value
);

   // front to queue
   logic          push;
   entry_type     push_data;
   fifo_stat_type fifo_stat;

   // queue to back
   entry_type     head;
   logic          pop;

   // classify: max channel, sector, delta and the signed hue difference
   hsv_front u_front (
      .start     (start),
      .busy      (busy),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_data (push_data)
   );

   // the back end takes an item every cycle, so any waiting item is popped
   assign pop = fifo_stat.not_empty;

   hsv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   // hue and saturation quotients, sector base, wrap, result register
   hsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .load           (pop),
      .load_data      (head),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value)
   );

   // every accepted item shows up as a result strobe
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LAT rsp_strobe)
      else $error("accepted item produced no result");

   // the back end drains one item a cycle, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled although back end never stalls");

endmodule
